[sv/aot_pkg.sv]
package aot_pkg;

  localparam int LOOKUP_DEPTH = 1024;
  localparam int LG_DEPTH     = $clog2(LOOKUP_DEPTH);
  localparam int STEP_SHIFT   = 16 - LG_DEPTH;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int GAIN_W   = 16;
  localparam int W_W      = 16;
  localparam int WROM_W   = 17;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = PROD_W + LG_DEPTH;
  localparam int VEL_W    = 16;
  localparam int REL_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0]        Q15_ONE   = 16'h8000;
  localparam logic [MAG_W-1:0]   MAG_MAX   = 15'h7fff;
  localparam logic [15:0]        SLOPE_MAX = 16'h7fff;
  localparam logic [15:0]        SLOPE_MIN = 16'h8000;
  localparam logic [WROM_W-1:0]  W_FULL    = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_SHAPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMICS_AMOUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMICS_MODE   = 3'd7;

  typedef enum logic [1:0] {
    SHAPE_LINEAR   = 2'd0,
    SHAPE_CIRCULAR = 2'd1,
    SHAPE_INVERSE  = 2'd2
  } shape_t;

  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_MEASURE = 2'd1,
    PH_OPEN    = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_GAIN,
    SQ_STORE,
    SQ_WALK,
    SQ_DRAIN,
    SQ_EVAL,
    SQ_VMUL,
    SQ_VEL,
    SQ_FIN
  } seq_t;

  typedef struct packed {
    logic clr;
    logic acc;
  } mac_ctl_t;

  typedef struct packed {
    logic                en;
    logic [LG_DEPTH-1:0] addr;
    logic [MAG_W-1:0]    data;
  } ring_wr_t;

  typedef struct packed {
    logic ring_we;
    logic start;
    logic walk;
    logic drain;
    logic eval;
    logic vel;
    logic load;
  } seq_ctl_t;

  typedef logic [WROM_W-1:0] wtab_t [LOOKUP_DEPTH];

  function automatic logic [WROM_W-1:0] isqrt34(input logic [33:0] x);
    logic [33:0] rem;
    logic [33:0] res;
    logic [33:0] bitv;
    int          i;
    rem  = x;
    res  = '0;
    bitv = 34'h1_0000_0000;
    for (i = 0; i < 17; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[WROM_W-1:0];
  endfunction

  // entry j: isqrt(2^32 - (j * 2^STEP_SHIFT)^2), quarter circle in Q1.16
  function automatic wtab_t build_wtab();
    wtab_t       tab;
    logic [33:0] t;
    logic [33:0] x;
    int          j;
    for (j = 0; j < LOOKUP_DEPTH; j++) begin
      t = 34'(j) << STEP_SHIFT;
      x = (34'd1 << 32) - t * t;
      tab[j] = isqrt34(x);
    end
    return tab;
  endfunction

endpackage

[sv/aot_ring.sv]
module aot_ring (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aot_pkg::ring_wr_t                wr,
  input  logic [aot_pkg::LG_DEPTH-1:0]     rd_addr,
  output logic [aot_pkg::MAG_W-1:0]        rd_data
);

  logic [aot_pkg::MAG_W-1:0] mem [aot_pkg::LOOKUP_DEPTH];
  logic [aot_pkg::MAG_W-1:0] rd_q_r;
  logic                      rd_ok_r;
  // entries at or above the fill count were never written and read as zero
  logic [aot_pkg::LG_DEPTH:0] fill_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= ({1'b0, rd_addr} < fill_r);
      if (wr.en && (fill_r != (aot_pkg::LG_DEPTH+1)'(aot_pkg::LOOKUP_DEPTH))) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

[sv/aot_wrom.sv]
module aot_wrom (
  input  logic                          clk,
  input  logic [aot_pkg::LG_DEPTH-1:0]  addr,
  output logic [aot_pkg::WROM_W-1:0]    q
);

  localparam aot_pkg::wtab_t WTAB = aot_pkg::build_wtab();

  logic [aot_pkg::WROM_W-1:0] q_r;

  always_ff @(posedge clk) begin
    q_r <= WTAB[addr];
  end

  assign q = q_r;

endmodule

[sv/aot_mac.sv]
module aot_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aot_pkg::mac_ctl_t                 ctl,
  input  logic signed [aot_pkg::MUL_W-1:0]  a0,
  input  logic signed [aot_pkg::MUL_W-1:0]  b0,
  input  logic signed [aot_pkg::MUL_W-1:0]  a1,
  input  logic signed [aot_pkg::MUL_W-1:0]  b1,
  output logic signed [aot_pkg::PROD_W-1:0] p0,
  output logic signed [aot_pkg::ACC_W-1:0]  acc0,
  output logic signed [aot_pkg::ACC_W-1:0]  acc1
);

  logic signed [aot_pkg::PROD_W-1:0] p0_r;
  logic signed [aot_pkg::PROD_W-1:0] p1_r;
  logic signed [aot_pkg::ACC_W-1:0]  acc0_r;
  logic signed [aot_pkg::ACC_W-1:0]  acc1_r;
  logic                              acc_en_r;

  always_ff @(posedge clk) begin
    p0_r <= a0 * b0;
    p1_r <= a1 * b1;
    if (ctl.clr) begin
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (acc_en_r) begin
      acc0_r <= acc0_r + aot_pkg::ACC_W'(p0_r);
      acc1_r <= acc1_r + aot_pkg::ACC_W'(p1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= ctl.acc;
    end
  end

  assign p0   = p0_r;
  assign acc0 = acc0_r;
  assign acc1 = acc1_r;

endmodule

[sv/audio_onset_trigger_core.sv]
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_stall   | in_sample_in
// out      | out_valid / out_stall | out_trigger_state, out_fired, out_hit,
//          |                       | out_velocity, out_level, out_slope,
//          |                       | out_gained_magnitude
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample runs from accept to result through a walk of 2^w window entries (w = window_log2,
// capped at log2 of the ring depth); the window walk feeds one ring entry and one weight
// per cycle into the multiplier pair, whose first lane is shared with the gain and velocity products.
// Reset needs no clearing pass: a fill count makes unwritten ring entries read as zero.
// in_stall is high for the whole item; a finished result waits in the output register
// and the last sequencer step holds only while a previous result is still stalled.
// cfg_ready is always high.
module audio_onset_trigger_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [aot_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_trigger_state,
  output logic                                 out_fired,
  output logic                                 out_hit,
  output logic [aot_pkg::VEL_W-1:0]            out_velocity,
  output logic [aot_pkg::MAG_W-1:0]            out_level,
  output logic signed [15:0]                   out_slope,
  output logic [aot_pkg::MAG_W-1:0]            out_gained_magnitude,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aot_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aot_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int LG = aot_pkg::LG_DEPTH;
  localparam logic [3:0]  LG_CAP  = 4'(LG);
  localparam logic [LG:0] DEPTH_V = (LG+1)'(aot_pkg::LOOKUP_DEPTH);

  // configuration
  logic [15:0]              gain_r;
  logic [3:0]               wlog_r;
  logic [1:0]               shape_r;
  logic [aot_pkg::MAG_W-1:0] open_thr_r;
  logic [aot_pkg::MAG_W-1:0] close_thr_r;
  logic [15:0]              rel_len_r;
  logic [15:0]              dyn_amt_r;
  logic                     dyn_mode_r;

  // sequencer and item state
  aot_pkg::seq_t            seq_r, seq_nxt;
  aot_pkg::seq_ctl_t        sctl;
  aot_pkg::phase_t          phase_r, phase_nxt;
  logic [aot_pkg::REL_W-1:0] release_r, release_nxt;
  logic [LG-1:0]            wp_r;
  logic [LG-1:0]            start_r;
  logic [LG:0]              k_r;
  logic                     v1_r;
  logic [LG-1:0]            jb_r;
  logic                     czero_r;
  logic [aot_pkg::W_W-1:0]  pw_r;
  logic [aot_pkg::MAG_W-1:0] pm_r;
  logic signed [aot_pkg::SAMPLE_W-1:0] sample_r;
  logic [aot_pkg::MAG_W-1:0] mag_r;
  logic [aot_pkg::MAG_W-1:0] level_r;
  logic [15:0]              slope_r;
  logic                     fired_r;
  logic                     hit_r;
  logic [aot_pkg::VEL_W-1:0] vel_r;

  // output register
  logic                      out_valid_r;
  logic [1:0]                out_trigger_state_r;
  logic                      out_fired_r;
  logic                      out_hit_r;
  logic [aot_pkg::VEL_W-1:0] out_velocity_r;
  logic [aot_pkg::MAG_W-1:0] out_level_r;
  logic [15:0]               out_slope_r;
  logic [aot_pkg::MAG_W-1:0] out_mag_r;

  // datapath wires
  logic [3:0]               lg;
  logic [3:0]               sh;
  logic [LG:0]              n_val;
  logic                     walk_last;
  logic [LG-1:0]            wp_inc;
  logic [LG:0]              start_full;
  logic [LG-1:0]            ring_raddr;
  logic [LG-1:0]            j_cur;
  logic [LG:0]              circ_full;
  logic [LG-1:0]            rom_addr;
  logic [aot_pkg::WROM_W-1:0] rom_q;
  logic [aot_pkg::MAG_W-1:0] ring_q;
  aot_pkg::ring_wr_t        ring_wr;
  logic [aot_pkg::W_W-1:0]  w_cur;
  logic [aot_pkg::WROM_W-1:0] w_inv;
  logic signed [16:0]       dw;
  logic signed [15:0]       dm;
  logic [16:0]              absval;
  logic [aot_pkg::MAG_W-1:0] mag_sat;
  logic [15:0]              d_sat;
  logic [15:0]              one_minus_d;
  logic [15:0]              one_minus_lvl;
  logic [aot_pkg::MAG_W-1:0] level_sat;
  logic [15:0]              slope_sat;
  logic                     slope_pos;
  logic                     ge_open;
  logic                     le_close;
  logic                     fire_c;
  logic                     hit_c;
  logic [15:0]              vel_base;
  logic [16:0]              vel_sum;
  aot_pkg::mac_ctl_t        mac_ctl;
  logic signed [aot_pkg::MUL_W-1:0]  mac_a0, mac_b0, mac_a1, mac_b1;
  logic signed [aot_pkg::PROD_W-1:0] mac_p0;
  logic signed [aot_pkg::ACC_W-1:0]  acc0, acc1;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq_r != aot_pkg::SQ_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= 16'd4096;
      wlog_r      <= 4'd6;
      shape_r     <= aot_pkg::SHAPE_LINEAR;
      open_thr_r  <= '0;
      close_thr_r <= '0;
      rel_len_r   <= '0;
      dyn_amt_r   <= '0;
      dyn_mode_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aot_pkg::REG_INPUT_GAIN:      gain_r      <= cfg_data;
        aot_pkg::REG_WINDOW_LOG2:     wlog_r      <= cfg_data[3:0];
        aot_pkg::REG_DETECTOR_SHAPE:  shape_r     <= cfg_data[1:0];
        aot_pkg::REG_OPEN_THRESHOLD:  open_thr_r  <= cfg_data[aot_pkg::MAG_W-1:0];
        aot_pkg::REG_CLOSE_THRESHOLD: close_thr_r <= cfg_data[aot_pkg::MAG_W-1:0];
        aot_pkg::REG_RELEASE_LENGTH:  rel_len_r   <= cfg_data;
        aot_pkg::REG_DYNAMICS_AMOUNT: dyn_amt_r   <= cfg_data;
        aot_pkg::REG_DYNAMICS_MODE:   dyn_mode_r  <= cfg_data[0];
      endcase
    end
  end

  // window geometry
  always_comb begin
    lg         = (wlog_r > LG_CAP) ? LG_CAP : wlog_r;
    sh         = LG_CAP - lg;
    n_val      = {{LG{1'b0}}, 1'b1} << lg;
    walk_last  = (k_r == n_val - 1'b1);
    wp_inc     = wp_r + 1'b1;
    start_full = {1'b0, wp_inc} - n_val;
    ring_raddr = start_r + k_r[LG-1:0];
    j_cur      = k_r[LG-1:0] << sh;
    circ_full  = DEPTH_V - {1'b0, j_cur};
    if ((shape_r == aot_pkg::SHAPE_CIRCULAR) && (j_cur != '0)) begin
      rom_addr = circ_full[LG-1:0];
    end else begin
      rom_addr = j_cur;
    end
  end

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      aot_pkg::SQ_IDLE:  if (in_valid) seq_nxt = aot_pkg::SQ_GAIN;
      aot_pkg::SQ_GAIN:  seq_nxt = aot_pkg::SQ_STORE;
      aot_pkg::SQ_STORE: seq_nxt = aot_pkg::SQ_WALK;
      aot_pkg::SQ_WALK:  if (walk_last) seq_nxt = aot_pkg::SQ_DRAIN;
      aot_pkg::SQ_DRAIN: if (k_r[0]) seq_nxt = aot_pkg::SQ_EVAL;
      aot_pkg::SQ_EVAL:  seq_nxt = aot_pkg::SQ_VMUL;
      aot_pkg::SQ_VMUL:  seq_nxt = aot_pkg::SQ_VEL;
      aot_pkg::SQ_VEL:   seq_nxt = aot_pkg::SQ_FIN;
      aot_pkg::SQ_FIN:   if (!out_valid_r || !out_stall) seq_nxt = aot_pkg::SQ_IDLE;
      default:           seq_nxt = aot_pkg::SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sctl = '0;
    unique case (seq_r)
      aot_pkg::SQ_STORE: begin
        sctl.ring_we = 1'b1;
        sctl.start   = 1'b1;
      end
      aot_pkg::SQ_WALK:  sctl.walk  = 1'b1;
      aot_pkg::SQ_DRAIN: sctl.drain = 1'b1;
      aot_pkg::SQ_EVAL:  sctl.eval  = 1'b1;
      aot_pkg::SQ_VEL:   sctl.vel   = 1'b1;
      aot_pkg::SQ_FIN:   sctl.load  = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= aot_pkg::SQ_IDLE;
      phase_r   <= aot_pkg::PH_CLOSED;
      release_r <= '0;
      wp_r      <= '0;
      k_r       <= '0;
      v1_r      <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      v1_r  <= sctl.walk;
      if (sctl.start) begin
        wp_r <= wp_inc;
        k_r  <= '0;
      end else if (sctl.walk) begin
        k_r <= walk_last ? '0 : k_r + 1'b1;
      end else if (sctl.drain) begin
        k_r <= k_r + 1'b1;
      end
      if (sctl.eval) begin
        phase_r   <= phase_nxt;
        release_r <= release_nxt;
      end
    end
  end

  // input capture and per-item payload
  always_ff @(posedge clk) begin
    if ((seq_r == aot_pkg::SQ_IDLE) && in_valid) begin
      sample_r <= in_sample_in;
    end
    if (sctl.start) begin
      start_r <= start_full[LG-1:0];
      mag_r   <= mag_sat;
      pw_r    <= '0;
      pm_r    <= '0;
    end else if (v1_r) begin
      pw_r <= w_cur;
      pm_r <= ring_q;
    end
    if (sctl.walk) begin
      jb_r    <= j_cur;
      czero_r <= (j_cur == '0);
    end
    if (sctl.eval) begin
      level_r <= level_sat;
      slope_r <= slope_sat;
      fired_r <= fire_c;
      hit_r   <= hit_c;
    end
    if (sctl.vel) begin
      vel_r <= hit_r ? vel_sum[aot_pkg::VEL_W-1:0] : '0;
    end
  end

  // gain and magnitude
  always_comb begin
    if (sample_r[aot_pkg::SAMPLE_W-1]) begin
      absval = 17'h10000 - {1'b0, sample_r};
    end else begin
      absval = {1'b0, sample_r};
    end
    if (|mac_p0[aot_pkg::PROD_W-1:27]) begin
      mag_sat = aot_pkg::MAG_MAX;
    end else begin
      mag_sat = mac_p0[26:12];
    end
  end

  assign ring_wr.en   = sctl.ring_we;
  assign ring_wr.addr = wp_r;
  assign ring_wr.data = mag_sat;

  aot_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ring_wr),
    .rd_addr (ring_raddr),
    .rd_data (ring_q)
  );

  aot_wrom u_wrom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  // weight for the entry whose ring and table reads just landed
  always_comb begin
    w_inv = aot_pkg::W_FULL - rom_q;
    unique case (shape_r)
      aot_pkg::SHAPE_CIRCULAR: w_cur = czero_r ? '0 : rom_q[aot_pkg::W_W-1:0];
      aot_pkg::SHAPE_INVERSE:  w_cur = w_inv[aot_pkg::W_W-1:0];
      default:                 w_cur = {jb_r, {aot_pkg::STEP_SHIFT{1'b0}}};
    endcase
    dw = $signed({1'b0, w_cur}) - $signed({1'b0, pw_r});
    dm = $signed({1'b0, ring_q}) - $signed({1'b0, pm_r});
  end

  // velocity operands
  always_comb begin
    d_sat         = (dyn_amt_r > aot_pkg::Q15_ONE) ? aot_pkg::Q15_ONE : dyn_amt_r;
    one_minus_d   = aot_pkg::Q15_ONE - d_sat;
    one_minus_lvl = aot_pkg::Q15_ONE - {1'b0, level_r};
    vel_base      = dyn_mode_r ? {1'b0, level_r} : one_minus_d;
    vel_sum       = {1'b0, vel_base} + {1'b0, mac_p0[30:15]};
  end

  // shared multiplier operand select
  always_comb begin
    mac_ctl.clr = sctl.start;
    mac_ctl.acc = v1_r;
    mac_a1      = $signed({2'b0, w_cur});
    mac_b1      = aot_pkg::MUL_W'(dm);
    unique case (seq_r)
      aot_pkg::SQ_GAIN: begin
        mac_a0 = $signed({1'b0, absval});
        mac_b0 = $signed({2'b0, gain_r});
      end
      aot_pkg::SQ_VMUL: begin
        if (dyn_mode_r) begin
          mac_a0 = $signed({2'b0, one_minus_lvl});
          mac_b0 = $signed({2'b0, one_minus_d});
        end else begin
          mac_a0 = $signed({3'b0, level_r});
          mac_b0 = $signed({2'b0, d_sat});
        end
      end
      default: begin
        mac_a0 = aot_pkg::MUL_W'(dw);
        mac_b0 = $signed({3'b0, ring_q});
      end
    endcase
  end

  aot_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a0    (mac_a0),
    .b0    (mac_b0),
    .a1    (mac_a1),
    .b1    (mac_b1),
    .p0    (mac_p0),
    .acc0  (acc0),
    .acc1  (acc1)
  );

  // floor by 2^16, then saturate
  always_comb begin
    if (acc0[aot_pkg::ACC_W-1]) begin
      level_sat = '0;
    end else if (|acc0[aot_pkg::ACC_W-2:31]) begin
      level_sat = aot_pkg::MAG_MAX;
    end else begin
      level_sat = acc0[30:16];
    end
    if ((&acc1[aot_pkg::ACC_W-1:31]) || !(|acc1[aot_pkg::ACC_W-1:31])) begin
      slope_sat = acc1[31:16];
    end else if (acc1[aot_pkg::ACC_W-1]) begin
      slope_sat = aot_pkg::SLOPE_MIN;
    end else begin
      slope_sat = aot_pkg::SLOPE_MAX;
    end
    slope_pos = !acc1[aot_pkg::ACC_W-1] && (|acc1);
    ge_open   = (level_sat >= open_thr_r);
    le_close  = (level_sat <= close_thr_r);
  end

  // trigger machine next state
  always_comb begin
    phase_nxt   = phase_r;
    release_nxt = release_r;
    unique case (phase_r)
      aot_pkg::PH_CLOSED: begin
        if (ge_open && slope_pos) begin
          phase_nxt   = aot_pkg::PH_MEASURE;
          release_nxt = {1'b0, rel_len_r};
        end
      end
      aot_pkg::PH_MEASURE: begin
        if (ge_open && !slope_pos) phase_nxt = aot_pkg::PH_OPEN;
      end
      default: begin
        if (le_close && !slope_pos) begin
          if (release_r == '0) begin
            phase_nxt = aot_pkg::PH_CLOSED;
          end else begin
            release_nxt = release_r - 1'b1;
          end
        end else begin
          release_nxt = {1'b0, rel_len_r};
        end
      end
    endcase
  end

  // trigger machine outputs
  always_comb begin
    fire_c = 1'b0;
    hit_c  = 1'b0;
    unique case (phase_r)
      aot_pkg::PH_CLOSED:  fire_c = ge_open && slope_pos;
      aot_pkg::PH_MEASURE: begin
        fire_c = 1'b1;
        hit_c  = ge_open && !slope_pos;
      end
      default: ;
    endcase
  end

  // output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sctl.load) begin
      out_trigger_state_r <= phase_r;
      out_fired_r         <= fired_r;
      out_hit_r           <= hit_r;
      out_velocity_r      <= vel_r;
      out_level_r         <= level_r;
      out_slope_r         <= slope_r;
      out_mag_r           <= mag_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_trigger_state    = out_trigger_state_r;
  assign out_fired            = out_fired_r;
  assign out_hit              = out_hit_r;
  assign out_velocity         = out_velocity_r;
  assign out_level            = out_level_r;
  assign out_slope            = out_slope_r;
  assign out_gained_magnitude = out_mag_r;

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == aot_pkg::SQ_FIN) && out_valid_r && out_stall |=> (seq_r == aot_pkg::SQ_FIN))
    else $error("result finished over a stalled beat");

  a_hit_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> (out_trigger_state_r == aot_pkg::PH_OPEN) && out_fired_r)
    else $error("hit without entering open");

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> (out_velocity_r == '0))
    else $error("velocity set without hit");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == aot_pkg::SQ_WALK) |-> (k_r < n_val))
    else $error("walk ran past the window");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == aot_pkg::SQ_IDLE) && in_valid |=> (seq_r == aot_pkg::SQ_GAIN) && in_stall)
    else $error("accepted sample did not start the sequence");

endmodule
